@@ sv/fsa_pkg.sv @@
// shared constants and types for the fixed step accumulator
package fsa_pkg;

  localparam int MIN_STEP   = 1000;
  localparam int TIME_WIDTH = 32;
  localparam int ALPHA_BITS = 16;

  localparam int STEP_W  = 24;
  localparam int ACC_W   = 32;
  localparam int MSTEP_W = 8;
  localparam int TICK_W  = 64;
  localparam int DROP_W  = 33;
  localparam int ALPHA_W = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 248;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCUM   = 2'd2;

  localparam logic [STEP_W-1:0]  RST_STEP_PERIOD = 24'd16667;
  localparam logic [MSTEP_W-1:0] RST_MAX_STEPS   = 8'd8;
  localparam logic [ACC_W-1:0]   RST_MAX_ACCUM   = 32'd250000;

  localparam logic [63:0] CAP_LIM_WIDE = (TIME_WIDTH >= ACC_W) ?
                                         64'(34359738367) :
                                         ((64'd1 << TIME_WIDTH) - 64'd1);
  localparam logic [ACC_W-1:0] CAP_LIM = (TIME_WIDTH >= ACC_W) ? '1 : CAP_LIM_WIDE[ACC_W-1:0];

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [ACC_W-1:0]   cap;
    logic [MSTEP_W-1:0] msteps;
    logic               clamp;
  } cfg_eff_t;

endpackage

@@ sv/fsa_cfg.sv @@
// configuration registers and effective step, cap and step limit
module fsa_cfg import fsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_eff_t             eff
);

  logic [STEP_W-1:0]  step_period;
  logic [MSTEP_W-1:0] max_steps;
  logic [ACC_W-1:0]   max_accum;
  logic               clamp;
  logic [STEP_W-1:0]  step_v;
  logic [ACC_W-1:0]   cap_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= RST_STEP_PERIOD;
      max_steps   <= RST_MAX_STEPS;
      max_accum   <= RST_MAX_ACCUM;
      clamp       <= 1'b0;
    end else begin
      clamp <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_PERIOD: step_period <= cfg_wdata[STEP_W-1:0];
          REG_MAX_STEPS:   max_steps   <= cfg_wdata[MSTEP_W-1:0];
          REG_MAX_ACCUM: begin
            max_accum <= cfg_wdata[ACC_W-1:0];
            clamp     <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    step_v     = (step_period < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : step_period;
    cap_raw    = (max_accum < ACC_W'(step_v)) ? ACC_W'(step_v) : max_accum;
    eff.step   = step_v;
    eff.cap    = (cap_raw > CAP_LIM) ? CAP_LIM : cap_raw;
    eff.msteps = (max_steps == '0) ? MSTEP_W'(1) : max_steps;
    eff.clamp  = clamp;
  end

endmodule

@@ sv/fsa_div.sv @@
// restoring divider, one quotient bit per cycle, integer then fraction bits
module fsa_div import fsa_pkg::*; #(
  parameter int FRAC_W = ALPHA_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              done,
  output logic [ACC_W-1:0]  quot,
  output logic [FRAC_W-1:0] frac,
  output logic [STEP_W-1:0] rem
);

  localparam int NB    = ACC_W + FRAC_W;
  localparam int CNT_W = $clog2(NB + 1);

  logic [NB-1:0]     sh;
  logic [STEP_W-1:0] r;
  logic [STEP_W-1:0] r_next;
  logic [STEP_W-1:0] dvs;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;
  logic [CNT_W-1:0]  cnt;
  logic              run;

  always_comb begin
    trial  = {r, sh[NB-1]};
    diff   = trial - {1'b0, dvs};
    ge     = trial >= {1'b0, dvs};
    r_next = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        sh  <= {dividend, {FRAC_W{1'b0}}};
        r   <= '0;
        dvs <= divisor;
      end else if (run) begin
        sh  <= {sh[NB-2:0], ge};
        r   <= r_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ACC_W - 1)) begin
          rem <= r_next;
        end
        if (cnt == CNT_W'(NB - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = sh[NB-1:FRAC_W];
  assign frac = sh[FRAC_W-1:0];

endmodule

@@ sv/fixed_step_accumulator.sv @@
// fixed step accumulator: frame time in, step plan out over one shared divider
// path from request to the first edge that can take its result: a clear goes through S_SUM
// to S_FIN, an advance through S_SUM, S_DIV (the bit-serial divider), S_MUL and S_FIN
// throughput: one request at a time, the next taken the cycle after its result is loaded;
// a held result stalls only that load
// reset: accumulator and tick counter zero, registers to their default values
module fixed_step_accumulator import fsa_pkg::*; #(
  parameter int ALPHA_BITS = fsa_pkg::ALPHA_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // delta_time
  input  logic                  s_tuser,   // mode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // step_used, first_tick, step_count,
                                           // dropped_time, alpha, accum_now, ticks_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  cfg_eff_t eff;

  logic [2:0]          state;
  logic                is_clear;
  logic [31:0]         delta;
  logic [ACC_W-1:0]    acc;
  logic [TICK_W-1:0]   tick;
  logic [TICK_W-1:0]   first;
  logic [DROP_W-1:0]   drop_cap;
  logic [ACC_W-1:0]    sumc;
  logic [ACC_W-1:0]    base;
  logic [ACC_W-1:0]    prod;
  logic [MSTEP_W-1:0]  cnt8;

  logic                div_start;
  logic                div_done;
  logic [ACC_W-1:0]    div_quot;
  logic [ALPHA_BITS-1:0] div_frac;
  logic [STEP_W-1:0]   div_rem;

  logic [ACC_W-1:0]    delta_pos;
  logic [DROP_W-1:0]   sum_wide;
  logic                fin_load;
  logic [ACC_W-1:0]    skip;
  logic [ALPHA_BITS+ALPHA_W-1:0] frac_ext;
  logic [DROP_W-1:0]   drop_v;
  logic [TICK_W-1:0]   ticks_v;

  fsa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .eff       (eff)
  );

  fsa_div #(.FRAC_W(ALPHA_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sumc),
    .divisor  (eff.step),
    .done     (div_done),
    .quot     (div_quot),
    .frac     (div_frac),
    .rem      (div_rem)
  );

  assign s_tready = (state == S_IDLE);

  always_comb begin
    delta_pos = delta[31] ? '0 : delta;
    sum_wide  = DROP_W'(acc) + DROP_W'(delta_pos);
    fin_load  = (state == S_FIN) && (!m_tvalid || m_tready);
    skip      = base - prod;
    frac_ext  = {{ALPHA_W{1'b0}}, div_frac};
    drop_v    = drop_cap + DROP_W'(skip);
    ticks_v   = tick + TICK_W'(cnt8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      acc       <= '0;
      tick      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            is_clear <= s_tuser;
            delta    <= s_tdata;
            state    <= S_SUM;
          end
        end
        S_SUM: begin
          first <= tick + TICK_W'(1);
          if (is_clear) begin
            state <= S_FIN;
          end else begin
            if (sum_wide > DROP_W'(eff.cap)) begin
              drop_cap <= sum_wide - DROP_W'(eff.cap);
              sumc     <= eff.cap;
            end else begin
              drop_cap <= '0;
              sumc     <= sum_wide[ACC_W-1:0];
            end
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            cnt8  <= (div_quot < ACC_W'(eff.msteps)) ? div_quot[MSTEP_W-1:0] : eff.msteps;
            base  <= sumc - ACC_W'(div_rem);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= ACC_W'({{(ACC_W-MSTEP_W){1'b0}}, cnt8} * {{(ACC_W-STEP_W){1'b0}}, eff.step});
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
            if (is_clear) begin
              acc     <= '0;
              tick    <= '0;
              m_tdata <= {7'd0, {TICK_W{1'b0}}, {ACC_W{1'b0}}, {ALPHA_W{1'b0}},
                          {DROP_W{1'b0}}, {MSTEP_W{1'b0}}, TICK_W'(1), eff.step};
            end else begin
              acc     <= ACC_W'(div_rem);
              tick    <= ticks_v;
              m_tdata <= {7'd0, ticks_v, ACC_W'(div_rem), frac_ext[ALPHA_W-1:0],
                          drop_v, cnt8, first, eff.step};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (!fin_load && eff.clamp && (acc > eff.cap)) begin
        acc <= eff.cap;
      end
    end
  end

endmodule
